### rtl/tssc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// TTL tagged slot cache package
// Shared widths, operation and status codes, and the command bundle that the
// top level broadcasts to every slot.
// ----------------------------------------------------------------------------
package tssc_pkg;

   localparam int TAG_W       = 32;
   localparam int TTL_W       = 8;
   localparam int OP_W        = 2;
   localparam int SLOT_OUT_W  = 6;
   localparam int FREED_OUT_W = 7;

   // Reset value of the TTL reload register.
   localparam logic [TTL_W-1:0] TTL_RELOAD_RESET = 8'd6;

   // Operation codes carried on the request tuser.
   localparam logic [OP_W-1:0] OP_LOOKUP = 2'd0;
   localparam logic [OP_W-1:0] OP_TICK   = 2'd1;
   localparam logic [OP_W-1:0] OP_CLEAR  = 2'd2;

   // Result status codes carried on the response tuser.
   typedef enum logic [1:0] {
      ST_HIT   = 2'd0,
      ST_ALLOC = 2'd1,
      ST_FULL  = 2'd2,
      ST_DONE  = 2'd3
   } status_type;

   // Command broadcast to every slot in the cycle a request is executed.
   typedef struct packed {
      logic             tick;
      logic             clear;
      logic [TTL_W-1:0] load_value;
      logic [TAG_W-1:0] tag;
   } slot_cmd_type;

endpackage

### rtl/tssc_slot.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// TTL tagged slot cache: one slot
// Holds one tag and its TTL count, compares the tag with the request and
// applies reload, allocation, ageing and clearing.
// ----------------------------------------------------------------------------
module tssc_slot (
   input  logic                  clock,
   input  logic                  reset,
   input  tssc_pkg::slot_cmd_type cmd,
   input  logic                  load_en,
   input  logic                  alloc_en,
   output logic                  live,
   output logic                  match,
   output logic                  expire
);
   import tssc_pkg::*;

   logic [TAG_W-1:0] tag_ff;
   logic [TAG_W-1:0] tag_in;
   logic [TTL_W-1:0] ttl_ff;
   logic [TTL_W-1:0] ttl_in;

   // A slot is live while its TTL is nonzero; only live slots can match.
   assign live   = (ttl_ff != '0);
   assign match  = live && (tag_ff == cmd.tag);
   assign expire = live && (ttl_ff == TTL_W'(1));

   // Next TTL and tag.
   always_comb begin
      ttl_in = ttl_ff;
      tag_in = tag_ff;
      if (cmd.clear) begin
         ttl_in = '0;
      end else if (cmd.tick) begin
         if (live) begin
            ttl_in = ttl_ff - TTL_W'(1);
         end
      end else if (load_en) begin
         ttl_in = cmd.load_value;
         if (alloc_en) begin
            tag_in = cmd.tag;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ttl_ff <= '0;
      end else begin
         ttl_ff <= ttl_in;
      end
   end

   // The tag is only ever compared while the slot is live.
   always_ff @(posedge clock) begin
      tag_ff <= tag_in;
   end

endmodule

### rtl/tssc_select.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// TTL tagged slot cache: slot selection
// Finds the lowest matching slot and the lowest free slot, and counts the
// slots that a tick or a clear frees.
// ----------------------------------------------------------------------------
module tssc_select #(
   parameter int ENTRIES = 64
) (
   input  logic [ENTRIES-1:0]                 match_vec,
   input  logic [ENTRIES-1:0]                 free_vec,
   input  logic [ENTRIES-1:0]                 freed_vec,
   output logic                               hit,
   output logic [$clog2(ENTRIES)-1:0]         hit_idx,
   output logic                               any_free,
   output logic [$clog2(ENTRIES)-1:0]         free_idx,
   output logic [$clog2(ENTRIES+1)-1:0]       freed_cnt
);
   localparam int IDX_W = $clog2(ENTRIES);
   localparam int CNT_W = $clog2(ENTRIES + 1);

   assign hit      = |match_vec;
   assign any_free = |free_vec;

   // Lowest-index priority encoders: scanning downwards leaves the lowest set bit.
   always_comb begin
      hit_idx  = '0;
      free_idx = '0;
      for (int i = ENTRIES - 1; i >= 0; i--) begin
         if (match_vec[i]) begin
            hit_idx = IDX_W'(i);
         end
         if (free_vec[i]) begin
            free_idx = IDX_W'(i);
         end
      end
   end

   // Population count of the freed slots.
   always_comb begin
      freed_cnt = '0;
      for (int i = 0; i < ENTRIES; i++) begin
         freed_cnt = freed_cnt + CNT_W'(freed_vec[i]);
      end
   end

endmodule

### rtl/ttl_tagged_slot_cache.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// TTL tagged slot cache
// Fully associative table of tagged slots with time-to-live expiry.
// ----------------------------------------------------------------------------
// Usage:
//   Requests arrive on the req_ stream: tuser carries the operation (lookup,
//   tick or clear) and tdata the 32-bit tag. Every request gives exactly one
//   response beat on the rsp_ stream: tuser carries the status, tdata the
//   slot index and the number of slots freed.
//   A request beat is captured in an input register; when the output register
//   is free or its beat is being taken, all slots are compared, the state is
//   updated and the result is written to the output register, which drives rsp_tvalid.
//   One request is taken every cycle while the receiver takes each response: the
//   whole lookup, allocation, ageing or clear is done by one pass through the tag
//   comparators, the priority encoders and the freed-slot counter.
//   If the receiver stalls, the result waits in the output register and the
//   input register still takes one further beat; req_tready then drops until
//   the response is taken.
//   The csr_ port writes the TTL reload value and is always ready; the user must
//   write it only while no request is in flight, as the block does not enforce it.
//   Reset frees every slot and sets the reload value to 6.
// ----------------------------------------------------------------------------
module ttl_tagged_slot_cache #(
   parameter int ENTRIES = 64
) (
   input  logic                          clock,
   input  logic                          reset,
   // Request stream.
   input  logic                          req_tvalid,
   output logic                          req_tready,
   input  logic [tssc_pkg::TAG_W-1:0]    req_tdata,   // [31:0] tag
   input  logic [tssc_pkg::OP_W-1:0]     req_tuser,   // [1:0] op
   // Response stream.
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   output logic [15:0]                   rsp_tdata,   // [5:0] slot, [12:6] freed_count
   output logic [1:0]                    rsp_tuser,   // [1:0] status
   // Register write channel.
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [tssc_pkg::TTL_W-1:0]    csr_data     // ttl_reload
);
   import tssc_pkg::*;

   localparam int IDX_W = $clog2(ENTRIES);
   localparam int CNT_W = $clog2(ENTRIES + 1);

   logic [TTL_W-1:0]       reload_ff;
   logic [TTL_W-1:0]       reload_in;

   logic                   in_valid_ff;
   logic                   in_valid_in;
   logic [OP_W-1:0]        in_op_ff;
   logic [TAG_W-1:0]       in_tag_ff;

   logic                   rsp_valid_ff;
   logic                   rsp_valid_in;
   status_type             rsp_status_ff;
   status_type             rsp_status_in;
   logic [SLOT_OUT_W-1:0]  rsp_slot_ff;
   logic [SLOT_OUT_W-1:0]  rsp_slot_in;
   logic [FREED_OUT_W-1:0] rsp_freed_ff;
   logic [FREED_OUT_W-1:0] rsp_freed_in;

   logic                   exec;
   logic                   lookup;
   slot_cmd_type           cmd;

   logic [ENTRIES-1:0]     live_vec;
   logic [ENTRIES-1:0]     match_vec;
   logic [ENTRIES-1:0]     expire_vec;
   logic [ENTRIES-1:0]     freed_vec;
   logic [ENTRIES-1:0]     load_en;
   logic [ENTRIES-1:0]     alloc_en;

   logic                   hit;
   logic [IDX_W-1:0]       hit_idx;
   logic                   any_free;
   logic [IDX_W-1:0]       free_idx;
   logic [CNT_W-1:0]       freed_cnt;

   // Register write port.
   assign csr_ready = 1'b1;
   assign reload_in = (csr_valid && csr_ready) ? csr_data : reload_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         reload_ff <= TTL_RELOAD_RESET;
      end else begin
         reload_ff <= reload_in;
      end
   end

   // The request in the input register executes when the output register is free.
   assign exec       = in_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || exec;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_tvalid && req_tready) begin
         in_valid_in = 1'b1;
      end else if (exec) begin
         in_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         in_op_ff  <= req_tuser;
         in_tag_ff <= req_tdata;
      end
   end

   // Command broadcast; a reload of zero loads one so the slot stays live.
   assign lookup         = exec && (in_op_ff == OP_LOOKUP);
   assign cmd.tick       = exec && (in_op_ff == OP_TICK);
   assign cmd.clear      = exec && (in_op_ff == OP_CLEAR);
   assign cmd.load_value = (reload_ff == '0) ? TTL_W'(1) : reload_ff;
   assign cmd.tag        = in_tag_ff;

   // Slot array.
   for (genvar g = 0; g < ENTRIES; g++) begin : g_slot
      assign alloc_en[g] = lookup && !hit && any_free && (free_idx == IDX_W'(g));
      assign load_en[g]  = alloc_en[g] || (lookup && hit && (hit_idx == IDX_W'(g)));

      tssc_slot u_slot (
         .clock    (clock),
         .reset    (reset),
         .cmd      (cmd),
         .load_en  (load_en[g]),
         .alloc_en (alloc_en[g]),
         .live     (live_vec[g]),
         .match    (match_vec[g]),
         .expire   (expire_vec[g])
      );
   end

   // A clear frees every live slot, a tick those down to their last count.
   assign freed_vec = (in_op_ff == OP_CLEAR) ? live_vec : expire_vec;

   tssc_select #(
      .ENTRIES (ENTRIES)
   ) u_select (
      .match_vec (match_vec),
      .free_vec  (~live_vec),
      .freed_vec (freed_vec),
      .hit       (hit),
      .hit_idx   (hit_idx),
      .any_free  (any_free),
      .free_idx  (free_idx),
      .freed_cnt (freed_cnt)
   );

   // Result formation.
   always_comb begin
      rsp_status_in = ST_DONE;
      rsp_slot_in   = '0;
      rsp_freed_in  = '0;
      case (in_op_ff)
         OP_LOOKUP: begin
            if (hit) begin
               rsp_status_in = ST_HIT;
               rsp_slot_in   = SLOT_OUT_W'(hit_idx);
            end else if (any_free) begin
               rsp_status_in = ST_ALLOC;
               rsp_slot_in   = SLOT_OUT_W'(free_idx);
            end else begin
               rsp_status_in = ST_FULL;
            end
         end
         OP_TICK, OP_CLEAR: begin
            rsp_freed_in = FREED_OUT_W'(freed_cnt);
         end
         default: begin
            rsp_status_in = ST_DONE;
         end
      endcase
   end

   // Output register: holds its beat until the receiver takes it.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (exec) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (exec) begin
         rsp_status_ff <= rsp_status_in;
         rsp_slot_ff   <= rsp_slot_in;
         rsp_freed_ff  <= rsp_freed_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_status_ff;
   assign rsp_tdata  = {3'b000, rsp_freed_ff, rsp_slot_ff};

   // Assertions.
   a_single_load : assert property (@(posedge clock) disable iff (reset)
      $onehot0(load_en))
      else $error("More than one slot loaded by one lookup.");

   a_clear_empties : assert property (@(posedge clock) disable iff (reset)
      cmd.clear |=> (live_vec == '0))
      else $error("A slot is still live after a clear.");

   a_full_only_when_full : assert property (@(posedge clock) disable iff (reset)
      (lookup && (rsp_status_in == ST_FULL)) |-> (live_vec == '1))
      else $error("Table reported full with a free slot.");

   a_lookup_frees_none : assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && (rsp_status_ff != ST_DONE)) |-> (rsp_freed_ff == '0))
      else $error("Lookup result carries a freed count.");

endmodule

### test/ttl_tagged_slot_cache_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// TTL tagged slot cache checker
// Watches the request, response and register channels of the slot cache,
// keeps its own copy of the slot table and the reload value, works out the
// response due for every accepted request beat and compares each accepted
// response beat, field by field, with the oldest one still due.
// ----------------------------------------------------------------------------
module ttl_tagged_slot_cache_checker #(
   parameter int ENTRIES = 64
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_tvalid,
   input  logic                          req_tready,
   input  logic [tssc_pkg::TAG_W-1:0]    req_tdata,   // [31:0] tag
   input  logic [tssc_pkg::OP_W-1:0]     req_tuser,   // [1:0] op
   input  logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   input  logic [15:0]                   rsp_tdata,   // [5:0] slot, [12:6] freed_count
   input  logic [1:0]                    rsp_tuser,   // [1:0] status
   input  logic                          csr_valid,
   input  logic                          csr_ready,
   input  logic [tssc_pkg::TTL_W-1:0]    csr_data,    // ttl_reload
   output int                            error_count,
   output int                            outstanding
);

   import tssc_pkg::*;

   typedef struct packed {
      status_type                status;
      logic [SLOT_OUT_W-1:0]     slot;
      logic [FREED_OUT_W-1:0]    freed;
   } cache_result_type;

   // Shadow copy of the slot table and the reload register.
   logic [TAG_W-1:0]   shadow_tags [ENTRIES];
   logic [TTL_W-1:0]   shadow_ttls [ENTRIES];
   logic [TTL_W-1:0]   shadow_reload;

   cache_result_type   due_results [$];
   cache_result_type   oldest_due;
   int                 mismatches = 0;

   initial begin
      error_count = 0;
      outstanding = 0;
   end

   // Applies one request to the shadow table and returns the response due.
   function automatic cache_result_type serve_request(input logic [OP_W-1:0] op,
                                                      input logic [TAG_W-1:0] tag);
      cache_result_type  res;
      logic [TTL_W-1:0]  load;
      int                hit_idx;
      int                free_idx;
      int                freed;
      int                i;
      res.status = ST_DONE;
      res.slot   = '0;
      res.freed  = '0;
      hit_idx    = -1;
      free_idx   = -1;
      freed      = 0;
      // A reload of zero still leaves a touched slot live for one tick.
      load = (shadow_reload == '0) ? TTL_W'(1) : shadow_reload;
      case (op)
         OP_LOOKUP: begin
            // Only live slots may match; the lowest match and free slot win.
            for (i = 0; i < ENTRIES; i++) begin
               if (shadow_ttls[i] != '0) begin
                  if (hit_idx < 0 && shadow_tags[i] == tag) hit_idx = i;
               end else if (free_idx < 0) begin
                  free_idx = i;
               end
            end
            if (hit_idx >= 0) begin
               shadow_ttls[hit_idx] = load;
               res.status = ST_HIT;
               res.slot   = SLOT_OUT_W'(hit_idx);
            end else if (free_idx >= 0) begin
               shadow_tags[free_idx] = tag;
               shadow_ttls[free_idx] = load;
               res.status = ST_ALLOC;
               res.slot   = SLOT_OUT_W'(free_idx);
            end else begin
               res.status = ST_FULL;
            end
         end
         OP_TICK: begin
            for (i = 0; i < ENTRIES; i++) begin
               if (shadow_ttls[i] != '0) begin
                  shadow_ttls[i] = shadow_ttls[i] - TTL_W'(1);
                  if (shadow_ttls[i] == '0) begin
                     shadow_tags[i] = '0;
                     freed++;
                  end
               end
            end
            res.freed = FREED_OUT_W'(freed);
         end
         OP_CLEAR: begin
            for (i = 0; i < ENTRIES; i++) begin
               if (shadow_ttls[i] != '0) freed++;
               shadow_ttls[i] = '0;
               shadow_tags[i] = '0;
            end
            res.freed = FREED_OUT_W'(freed);
         end
         default: begin
            // The unused code leaves the table alone.
         end
      endcase
      return res;
   endfunction

   // Responses are checked before the request of the same edge is predicted,
   // since a response always belongs to an earlier request.
   always @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < ENTRIES; i++) begin
            shadow_tags[i] = '0;
            shadow_ttls[i] = '0;
         end
         shadow_reload = TTL_RELOAD_RESET;
         due_results.delete();
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (due_results.size() == 0) begin
               $display("%0t: response beat with nothing due: expected none, %s %0d tdata %h",
                        $time, "got status", rsp_tuser, rsp_tdata);
               mismatches++;
            end else begin
               oldest_due = due_results.pop_front();
               if (rsp_tuser !== oldest_due.status) begin
                  $display("%0t: status mismatch: expected %0d, got %0d",
                           $time, oldest_due.status, rsp_tuser);
                  mismatches++;
               end
               if (rsp_tdata[5:0] !== oldest_due.slot) begin
                  $display("%0t: slot mismatch: expected %0d, got %0d",
                           $time, oldest_due.slot, rsp_tdata[5:0]);
                  mismatches++;
               end
               if (rsp_tdata[12:6] !== oldest_due.freed) begin
                  $display("%0t: freed_count mismatch: expected %0d, got %0d",
                           $time, oldest_due.freed, rsp_tdata[12:6]);
                  mismatches++;
               end
               if (rsp_tdata[15:13] !== 3'b000) begin
                  $display("%0t: tdata padding mismatch: expected 0, got %b",
                           $time, rsp_tdata[15:13]);
                  mismatches++;
               end
            end
         end
         if (csr_valid && csr_ready) shadow_reload = csr_data;
         if (req_tvalid && req_tready) due_results.push_back(serve_request(req_tuser, req_tdata));
      end
      error_count <= mismatches;
      outstanding <= due_results.size();
   end

endmodule

### test/tb_ttl_tagged_slot_cache.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// TTL tagged slot cache testbench
// Drives lookups, ticks, clears and the unused code into the slot cache under
// a series of reload values, with random gaps on the request side and random
// back-pressure on the response side, and leaves all checking to the checker.
// ----------------------------------------------------------------------------
module tb_ttl_tagged_slot_cache;

   import tssc_pkg::*;

   localparam int              ENTRIES        = 64;
   localparam int              WATCHDOG_LIMIT = 2000;
   localparam int              PHASE_COUNT    = 7;
   localparam int              PHASE_BEATS    = 236;
   localparam logic [OP_W-1:0] OP_UNUSED      = 2'd3;

   logic                clock      = 1'b0;
   logic                reset      = 1'b1;
   logic                req_tvalid = 1'b0;
   logic                req_tready;
   logic [TAG_W-1:0]    req_tdata  = '0;
   logic [OP_W-1:0]     req_tuser  = '0;
   logic                rsp_tvalid;
   logic                rsp_tready = 1'b0;
   logic [15:0]         rsp_tdata;
   logic [1:0]          rsp_tuser;
   logic                csr_valid  = 1'b0;
   logic                csr_ready;
   logic [TTL_W-1:0]    csr_data   = '0;

   int                  error_count;
   int                  outstanding;
   int                  send_idle_pct = 19;
   int                  recv_idle_pct = 74;
   int                  beats_sent    = 0;
   int                  quiet_cycles  = 0;

   ttl_tagged_slot_cache #(.ENTRIES(ENTRIES)) DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   ttl_tagged_slot_cache_checker #(.ENTRIES(ENTRIES)) cache_check (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_data    (csr_data),
      .error_count (error_count),
      .outstanding (outstanding)
   );

   initial begin
      forever #2 clock = ~clock;
   end

   // Random back-pressure on the response side.
   always @(posedge clock) begin
      rsp_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
   end

   // Watchdog: ends the run after too long without any accepted beat.
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("tb_ttl_tagged_slot_cache: done, errors");
         $finish;
      end
   end

   // Sends one request beat after an optional random gap. Ready is sampled
   // on the falling edge, where nothing is changing.
   task automatic send_request(input logic [OP_W-1:0] op, input logic [TAG_W-1:0] tag);
      bit took;
      // Idling pattern follows the progress of the run.
      if (beats_sent < 550) begin
         send_idle_pct = 19;
         recv_idle_pct = 74;
      end else if (beats_sent < 1100) begin
         send_idle_pct = 74;
         recv_idle_pct = 19;
      end else begin
         send_idle_pct = 0;
         recv_idle_pct = 0;
      end
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= tag;
      do begin
         @(negedge clock);
         took = req_tready;
         @(posedge clock);
      end while (!took);
      beats_sent++;
   endtask

   // Holds the request side off until every due response has been taken.
   task automatic drain_responses();
      req_tvalid <= 1'b0;
      @(negedge clock);
      while (outstanding != 0) @(negedge clock);
      @(posedge clock);
   endtask

   // Writes the reload register once the cache is idle.
   task automatic write_reload(input logic [TTL_W-1:0] value);
      bit took;
      drain_responses();
      csr_valid <= 1'b1;
      csr_data  <= value;
      do begin
         @(negedge clock);
         took = csr_ready;
         @(posedge clock);
      end while (!took);
      csr_valid <= 1'b0;
   endtask

   // Tags mostly come from a small pool so that hits and expiry happen often;
   // pool entry zero is the tag that free slots hold.
   function automatic logic [TAG_W-1:0] pick_tag(input int pool);
      int r;
      r = $urandom_range(0, 99);
      if (r < 85) return TAG_W'($urandom_range(0, pool - 1)) * 32'h9E37_79B1;
      if (r < 95) return $urandom;
      if (r < 97) return '1;
      return '0;
   endfunction

   function automatic logic [OP_W-1:0] pick_op(input int tick_pct, input int clear_pct);
      int r;
      r = $urandom_range(0, 99);
      if (r < tick_pct) return OP_TICK;
      if (r < tick_pct + clear_pct) return OP_CLEAR;
      if (r < tick_pct + clear_pct + 3) return OP_UNUSED;
      return OP_LOOKUP;
   endfunction

   initial begin
      int               pool;
      int               tick_pct;
      int               clear_pct;
      logic [TTL_W-1:0] reload;

      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // Directed part at the reset reload value.
      send_request(OP_LOOKUP, 32'h0000_0000);  // tag zero on an empty table allocates
      send_request(OP_LOOKUP, 32'h0000_0000);
      send_request(OP_LOOKUP, 32'hFFFF_FFFF);
      send_request(OP_LOOKUP, 32'hFFFF_FFFF);
      send_request(OP_UNUSED, 32'h1234_5678);
      send_request(OP_TICK,   32'hDEAD_BEEF);
      send_request(OP_CLEAR,  32'h0000_0000);
      // A freed slot keeps tag zero but must not hit.
      send_request(OP_LOOKUP, 32'h0000_0000);
      repeat (6) send_request(OP_TICK, 32'h0000_0000);
      send_request(OP_LOOKUP, 32'hA5A5_A5A5);
      send_request(OP_LOOKUP, 32'h5A5A_5A5A);
      send_request(OP_LOOKUP, 32'hA5A5_A5A5);
      send_request(OP_CLEAR,  32'hFFFF_FFFF);
      send_request(OP_CLEAR,  32'h0000_0000);

      // Random phases, each under its own reload value and traffic mix.
      for (int phase = 0; phase < PHASE_COUNT; phase++) begin
         case (phase)
            0: begin reload = 8'd255; pool = 100; tick_pct = 2;  clear_pct = 0; end
            1: begin reload = 8'd0;   pool = 6;   tick_pct = 20; clear_pct = 1; end
            2: begin reload = 8'd1;   pool = 10;  tick_pct = 25; clear_pct = 1; end
            3: begin reload = 8'd3;   pool = 40;  tick_pct = 15; clear_pct = 1; end
            4: begin
               reload = TTL_W'($urandom_range(1, 255));
               pool = 70; tick_pct = 5; clear_pct = 1;
            end
            5: begin reload = 8'd6;   pool = 16;  tick_pct = 20; clear_pct = 1; end
            default: begin reload = 8'd2; pool = 80; tick_pct = 3; clear_pct = 0; end
         endcase
         write_reload(reload);
         for (int n = 0; n < PHASE_BEATS; n++) begin
            send_request(pick_op(tick_pct, clear_pct), pick_tag(pool));
         end
      end

      drain_responses();
      repeat (3) @(posedge clock);
      if (error_count == 0) begin
         $display("tb_ttl_tagged_slot_cache: done, clean");
      end else begin
         $display("tb_ttl_tagged_slot_cache: done, errors");
      end
      $finish;
   end

endmodule
